[rtl/core/node_rank_membership_table_defines.svh]
// ----------------------------------------------------------------------------
// node rank membership table assertion macros
// shared property shorthands for the checker
// ----------------------------------------------------------------------------
`ifndef NODE_RANK_MEMBERSHIP_TABLE_DEFINES_SVH
`define NODE_RANK_MEMBERSHIP_TABLE_DEFINES_SVH

// same-cycle implication
`define NRMT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nrmt check failed");

// next-cycle implication
`define NRMT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nrmt check failed");

`endif

[rtl/core/nrmt_pkg.sv]
// ----------------------------------------------------------------------------
// nrmt_pkg
// types and codes of the node rank membership table
// ----------------------------------------------------------------------------
package nrmt_pkg;

    localparam int DEF_TABLE_SIZE = 16;
    localparam int NODE_BITS      = 8;
    localparam int RANK_BITS      = 16;
    localparam int COUNT_BITS     = 5;
    localparam int MAX_RESULTS    = 16;

    localparam logic [31:0] TALK_SIG = 32'hfdb97531;
    localparam logic [15:0] TALK_LEN = 16'd8;

    localparam logic [2:0] ST_UNUSED = 3'd0;
    localparam logic [2:0] ST_WAITID = 3'd1;
    localparam logic [2:0] ST_NORANK = 3'd2;
    localparam logic [2:0] ST_ALMOST = 3'd3;
    localparam logic [2:0] ST_ACTIVE = 3'd4;

    localparam logic [2:0] ACT_INIT   = 3'd0;
    localparam logic [2:0] ACT_JOIN   = 3'd1;
    localparam logic [2:0] ACT_DROP   = 3'd2;
    localparam logic [2:0] ACT_RECV   = 3'd3;
    localparam logic [2:0] ACT_SENT   = 3'd4;
    localparam logic [2:0] ACT_ACTIVE = 3'd5;
    localparam logic [2:0] ACT_LK_RK  = 3'd6;
    localparam logic [2:0] ACT_LK_ND  = 3'd7;

    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_REJECT  = 2'd1;
    localparam logic [1:0] STS_UNKNOWN = 2'd2;
    localparam logic [1:0] STS_FULL    = 2'd3;

    localparam logic ADDR_NODE = 1'b0;

    typedef struct packed {
        logic [2:0]         action;
        logic [7:0]         node_id;
        logic               msg_is_talk;
        logic [15:0]        payload_len;
        logic [31:0]        payload_magic;
        logic [15:0]        peer_state;
        logic signed [15:0] rank_in;
    } req_t;

    typedef struct packed {
        logic               deliver;
        logic               talk_en;
        logic [7:0]         talk_dest;
        logic [2:0]         talk_state;
        logic signed [15:0] talk_rank;
        logic               found;
        logic signed [15:0] lookup_value;
        logic [1:0]         status;
        logic [4:0]         talked_count;
        logic [4:0]         ranked_count;
        logic [4:0]         active_count;
        logic               last;
    } rsp_t;

    function automatic logic is_talked(input logic [2:0] s);
        return (s == ST_NORANK) || (s == ST_ALMOST) || (s == ST_ACTIVE);
    endfunction

    function automatic logic is_ranked(input logic [2:0] s);
        return (s == ST_ALMOST) || (s == ST_ACTIVE);
    endfunction

endpackage

[rtl/core/node_rank_membership_table.sv]
// ----------------------------------------------------------------------------
// node_rank_membership_table
// peer table with node id, rank and state per entry; scans the table for
// every event, then reads, modifies and writes back at most one entry
// ----------------------------------------------------------------------------
// channel   | handshake                    | word
// request   | start, busy                  | req_t
// response  | response_strobe (no stall)   | rsp_t
// config    | psel, penable, pwrite, pready| 32 bit words
//
// an event scans the table, one memory read per entry, then applies the
// change and registers the result; go active with own entry and peers
// adds a second scan: one talk word per peer, up to MAX_RESULTS words
// reset clears all entry states and counts at once, no clearing pass
// the receiver cannot stall; results come one per cycle at most
// ----------------------------------------------------------------------------
module node_rank_membership_table
    import nrmt_pkg::*;
#(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_t        request,
    output logic        response_strobe,
    output rsp_t        response,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CW = $clog2(TABLE_SIZE + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [IW:0]          cnt_reg, cnt_next;
    logic                 d_vld_reg, d_vld_next;
    logic [IW-1:0]        d_idx_reg, d_idx_next;
    req_t                 req_reg, req_next;

    logic                 me_hit_reg, me_hit_next;
    logic [IW-1:0]        me_idx_reg, me_idx_next;
    logic [2:0]           me_st_reg, me_st_next;
    logic [15:0]          me_rk_reg, me_rk_next;
    logic                 id_hit_reg, id_hit_next;
    logic [IW-1:0]        id_idx_reg, id_idx_next;
    logic [2:0]           id_st_reg, id_st_next;
    logic [15:0]          id_rk_reg, id_rk_next;
    logic                 fr_hit_reg, fr_hit_next;
    logic [IW-1:0]        fr_idx_reg, fr_idx_next;
    logic                 tw_hit_reg, tw_hit_next;
    logic [IW-1:0]        tw_idx_reg, tw_idx_next;
    logic                 lk_hit_reg, lk_hit_next;
    logic [15:0]          lk_val_reg, lk_val_next;
    logic [CW-1:0]        peer_reg, peer_next;
    logic [4:0]           emit_reg, emit_next;

    logic [4:0]           talked_reg, talked_next;
    logic [4:0]           ranked_reg, ranked_next;
    logic [4:0]           active_reg, active_next;

    logic                 rsp_vld_reg, rsp_vld_next;
    rsp_t                 rsp_reg, rsp_next;

    logic [NODE_BITS-1:0] my_node_reg;
    logic [14:0]          my_rank_reg;

    logic [2:0]           ent_st_reg [TABLE_SIZE];
    logic [NODE_BITS-1:0] node_mem [TABLE_SIZE];
    logic [RANK_BITS-1:0] rank_mem [TABLE_SIZE];
    logic [NODE_BITS-1:0] rd_node_reg;
    logic [RANK_BITS-1:0] rd_rank_reg;

    logic                 st_we;
    logic                 mem_we;
    logic [IW-1:0]        wr_idx;
    logic [2:0]           wr_old;
    logic [2:0]           wr_new;
    logic [NODE_BITS-1:0] wr_node;
    logic [RANK_BITS-1:0] wr_rank;

    logic [2:0]           d_st;
    logic                 d_used;
    logic                 d_peer;
    logic                 is_talk;
    logic                 cur_joined;
    logic [IW-1:0]        cur_idx;
    logic [2:0]           cur_st;
    logic [15:0]          cur_rk;
    logic                 talk_ok;
    logic [15:0]          emit_ext;
    logic [15:0]          peer_ext;
    logic                 emit_last;

    assign busy            = (state_reg != S_IDLE);
    assign response_strobe = rsp_vld_reg;
    assign response        = rsp_reg;
    assign pready          = 1'b1;
    assign prdata          = (paddr[2] == ADDR_NODE) ? {24'd0, my_node_reg}
                                                     : {17'd0, my_rank_reg};

    assign d_st   = ent_st_reg[d_idx_reg];
    assign d_used = (d_st != ST_UNUSED);
    assign d_peer = d_used && (rd_node_reg != my_node_reg);

    assign is_talk   = (req_reg.payload_len == TALK_LEN) &&
                       (req_reg.payload_magic == TALK_SIG);
    assign emit_ext  = 16'(emit_reg) + 16'd1;
    assign peer_ext  = 16'(peer_reg);
    assign emit_last = (emit_ext == peer_ext) || (emit_ext == 16'(MAX_RESULTS));

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            my_node_reg <= '0;
            my_rank_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == ADDR_NODE)
                my_node_reg <= pwdata[NODE_BITS-1:0];
            else
                my_rank_reg <= pwdata[14:0];
        end
    end

    // entry states with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_SIZE; i++)
                ent_st_reg[i] <= ST_UNUSED;
        end
        else if (st_we)
        begin
            ent_st_reg[wr_idx] <= wr_new;
        end
    end

    // node and rank memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            node_mem[wr_idx] <= wr_node;
            rank_mem[wr_idx] <= wr_rank;
        end
        rd_node_reg <= node_mem[cnt_reg[IW-1:0]];
        rd_rank_reg <= rank_mem[cnt_reg[IW-1:0]];
    end

    // receive check on the scanned entry
    always_comb
    begin
        cur_joined = !id_hit_reg && fr_hit_reg;
        cur_idx    = id_hit_reg ? id_idx_reg : fr_idx_reg;
        cur_st     = id_hit_reg ? id_st_reg : ST_WAITID;
        cur_rk     = id_hit_reg ? id_rk_reg : 16'hffff;
        if (req_reg.rank_in[15])
            talk_ok = (req_reg.peer_state == 16'(ST_NORANK));
        else
            talk_ok = !(tw_hit_reg && (tw_idx_reg != cur_idx)) &&
                      ((req_reg.peer_state == 16'(ST_ALMOST)) ||
                       (req_reg.peer_state == 16'(ST_ACTIVE)));
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        d_vld_next   = 1'b0;
        d_idx_next   = cnt_reg[IW-1:0];
        req_next     = req_reg;
        me_hit_next  = me_hit_reg;
        me_idx_next  = me_idx_reg;
        me_st_next   = me_st_reg;
        me_rk_next   = me_rk_reg;
        id_hit_next  = id_hit_reg;
        id_idx_next  = id_idx_reg;
        id_st_next   = id_st_reg;
        id_rk_next   = id_rk_reg;
        fr_hit_next  = fr_hit_reg;
        fr_idx_next  = fr_idx_reg;
        tw_hit_next  = tw_hit_reg;
        tw_idx_next  = tw_idx_reg;
        lk_hit_next  = lk_hit_reg;
        lk_val_next  = lk_val_reg;
        peer_next    = peer_reg;
        emit_next    = emit_reg;
        talked_next  = talked_reg;
        ranked_next  = ranked_reg;
        active_next  = active_reg;
        rsp_vld_next = 1'b0;
        rsp_next     = rsp_reg;
        st_we        = 1'b0;
        mem_we       = 1'b0;
        wr_idx       = cur_idx;
        wr_old       = ST_UNUSED;
        wr_new       = ST_UNUSED;
        wr_node      = req_reg.node_id;
        wr_rank      = 16'hffff;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next    = request;
                    cnt_next    = '0;
                    me_hit_next = 1'b0;
                    id_hit_next = 1'b0;
                    fr_hit_next = 1'b0;
                    tw_hit_next = 1'b0;
                    lk_hit_next = 1'b0;
                    peer_next   = '0;
                    state_next  = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (cnt_reg < (IW + 1)'(TABLE_SIZE))
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    d_vld_next = 1'b1;
                end
                if (d_vld_reg)
                begin
                    if (d_used && !me_hit_reg && rd_node_reg == my_node_reg)
                    begin
                        me_hit_next = 1'b1;
                        me_idx_next = d_idx_reg;
                        me_st_next  = d_st;
                        me_rk_next  = rd_rank_reg;
                    end
                    if (d_used && !id_hit_reg && rd_node_reg == req_reg.node_id)
                    begin
                        id_hit_next = 1'b1;
                        id_idx_next = d_idx_reg;
                        id_st_next  = d_st;
                        id_rk_next  = rd_rank_reg;
                    end
                    if (!d_used && !fr_hit_reg)
                    begin
                        fr_hit_next = 1'b1;
                        fr_idx_next = d_idx_reg;
                    end
                    if (d_used && !tw_hit_reg && rd_rank_reg == req_reg.rank_in)
                    begin
                        tw_hit_next = 1'b1;
                        tw_idx_next = d_idx_reg;
                    end
                    if (is_ranked(d_st) && !lk_hit_reg)
                    begin
                        if (req_reg.action == ACT_LK_RK &&
                            rd_rank_reg == req_reg.rank_in)
                        begin
                            lk_hit_next = 1'b1;
                            lk_val_next = 16'(rd_node_reg);
                        end
                        else if (req_reg.action == ACT_LK_ND &&
                                 rd_node_reg == req_reg.node_id)
                        begin
                            lk_hit_next = 1'b1;
                            lk_val_next = rd_rank_reg;
                        end
                    end
                    if (d_peer)
                        peer_next = peer_reg + 1'b1;
                    if (d_idx_reg == IW'(TABLE_SIZE - 1))
                        state_next = S_APPLY;
                end
            end

            S_APPLY:
            begin
                rsp_vld_next = 1'b1;
                rsp_next     = '0;
                rsp_next.last = 1'b1;
                state_next   = S_IDLE;
                case (req_reg.action)
                    ACT_INIT:
                    begin
                        if (me_hit_reg || fr_hit_reg)
                        begin
                            st_we   = 1'b1;
                            mem_we  = 1'b1;
                            wr_idx  = me_hit_reg ? me_idx_reg : fr_idx_reg;
                            wr_old  = me_hit_reg ? me_st_reg : ST_UNUSED;
                            wr_new  = ST_ALMOST;
                            wr_node = my_node_reg;
                            wr_rank = {1'b0, my_rank_reg};
                        end
                        else
                            rsp_next.status = STS_FULL;
                    end
                    ACT_JOIN:
                    begin
                        if (id_hit_reg || fr_hit_reg)
                        begin
                            rsp_next.talk_en   = 1'b1;
                            rsp_next.talk_dest = req_reg.node_id;
                            if (me_hit_reg)
                            begin
                                rsp_next.talk_state = me_st_reg;
                                rsp_next.talk_rank  = me_rk_reg;
                            end
                            else if (!id_hit_reg && req_reg.node_id == my_node_reg)
                            begin
                                rsp_next.talk_state = ST_WAITID;
                                rsp_next.talk_rank  = 16'hffff;
                            end
                            else
                            begin
                                rsp_next.talk_state = ST_UNUSED;
                                rsp_next.talk_rank  = 16'hffff;
                            end
                            if (!id_hit_reg)
                            begin
                                st_we  = 1'b1;
                                mem_we = 1'b1;
                                wr_idx = fr_idx_reg;
                                wr_new = ST_WAITID;
                            end
                        end
                        else
                            rsp_next.status = STS_FULL;
                    end
                    ACT_DROP:
                    begin
                        if (id_hit_reg)
                        begin
                            st_we  = 1'b1;
                            wr_idx = id_idx_reg;
                            wr_old = id_st_reg;
                            wr_new = ST_UNUSED;
                        end
                        else
                            rsp_next.status = STS_UNKNOWN;
                    end
                    ACT_RECV:
                    begin
                        if (!req_reg.msg_is_talk)
                            rsp_next.deliver = 1'b1;
                        else if (!id_hit_reg && !fr_hit_reg)
                            rsp_next.status = STS_FULL;
                        else
                        begin
                            wr_idx = cur_idx;
                            wr_old = id_hit_reg ? id_st_reg : ST_UNUSED;
                            wr_new = ST_WAITID;
                            st_we  = cur_joined;
                            mem_we = cur_joined;
                            if (cur_st == ST_ACTIVE)
                            begin
                                if (is_talk)
                                    rsp_next.status = STS_REJECT;
                                else
                                    rsp_next.deliver = 1'b1;
                            end
                            else if (!is_talk)
                            begin
                                if (!cur_rk[15])
                                    rsp_next.deliver = 1'b1;
                                else
                                    rsp_next.status = STS_REJECT;
                            end
                            else if (!talk_ok)
                                rsp_next.status = STS_REJECT;
                            else
                            begin
                                st_we   = 1'b1;
                                mem_we  = 1'b1;
                                wr_new  = req_reg.peer_state[2:0];
                                wr_rank = req_reg.rank_in;
                            end
                        end
                    end
                    ACT_SENT:
                    begin
                        rsp_next.deliver = !req_reg.msg_is_talk;
                    end
                    ACT_ACTIVE:
                    begin
                        if (me_hit_reg)
                        begin
                            st_we  = 1'b1;
                            wr_idx = me_idx_reg;
                            wr_old = me_st_reg;
                            wr_new = ST_ACTIVE;
                            if (peer_reg != '0)
                            begin
                                rsp_vld_next = 1'b0;
                                cnt_next     = '0;
                                emit_next    = '0;
                                state_next   = S_EMIT;
                            end
                        end
                    end
                    default:
                    begin
                        rsp_next.found        = lk_hit_reg;
                        rsp_next.lookup_value = lk_hit_reg ? lk_val_reg : 16'hffff;
                    end
                endcase
                if (st_we)
                begin
                    talked_next = talked_reg - 5'(is_talked(wr_old)) + 5'(is_talked(wr_new));
                    ranked_next = ranked_reg - 5'(is_ranked(wr_old)) + 5'(is_ranked(wr_new));
                    active_next = active_reg - 5'(wr_old == ST_ACTIVE) +
                                  5'(wr_new == ST_ACTIVE);
                end
                rsp_next.talked_count = talked_next;
                rsp_next.ranked_count = ranked_next;
                rsp_next.active_count = active_next;
            end

            S_EMIT:
            begin
                if (cnt_reg < (IW + 1)'(TABLE_SIZE))
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    d_vld_next = 1'b1;
                end
                if (d_vld_reg)
                begin
                    if (d_peer && emit_reg < 5'(MAX_RESULTS))
                    begin
                        rsp_vld_next          = 1'b1;
                        rsp_next              = '0;
                        rsp_next.talk_en      = 1'b1;
                        rsp_next.talk_dest    = rd_node_reg;
                        rsp_next.talk_state   = ST_ACTIVE;
                        rsp_next.talk_rank    = me_rk_reg;
                        rsp_next.talked_count = talked_reg;
                        rsp_next.ranked_count = ranked_reg;
                        rsp_next.active_count = active_reg;
                        rsp_next.last         = emit_last;
                        emit_next             = emit_reg + 1'b1;
                    end
                    if (d_idx_reg == IW'(TABLE_SIZE - 1))
                        state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            d_vld_reg   <= 1'b0;
            me_hit_reg  <= 1'b0;
            id_hit_reg  <= 1'b0;
            fr_hit_reg  <= 1'b0;
            tw_hit_reg  <= 1'b0;
            lk_hit_reg  <= 1'b0;
            peer_reg    <= '0;
            emit_reg    <= '0;
            talked_reg  <= '0;
            ranked_reg  <= '0;
            active_reg  <= '0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            d_vld_reg   <= d_vld_next;
            me_hit_reg  <= me_hit_next;
            id_hit_reg  <= id_hit_next;
            fr_hit_reg  <= fr_hit_next;
            tw_hit_reg  <= tw_hit_next;
            lk_hit_reg  <= lk_hit_next;
            peer_reg    <= peer_next;
            emit_reg    <= emit_next;
            talked_reg  <= talked_next;
            ranked_reg  <= ranked_next;
            active_reg  <= active_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_idx_reg  <= d_idx_next;
        req_reg    <= req_next;
        me_idx_reg <= me_idx_next;
        me_st_reg  <= me_st_next;
        me_rk_reg  <= me_rk_next;
        id_idx_reg <= id_idx_next;
        id_st_reg  <= id_st_next;
        id_rk_reg  <= id_rk_next;
        fr_idx_reg <= fr_idx_next;
        tw_idx_reg <= tw_idx_next;
        lk_val_reg <= lk_val_next;
        rsp_reg    <= rsp_next;
    end

endmodule

[rtl/core/nrmt_checker.sv]
// ----------------------------------------------------------------------------
// nrmt_checker
// port level checks of the node rank membership table
// ----------------------------------------------------------------------------
`include "node_rank_membership_table_defines.svh"

module nrmt_checker
    import nrmt_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic response_strobe,
    input rsp_t response
);

    // a word only comes out of an event in flight
    `NRMT_ASSERT_NOW(a_strobe_after_busy, response_strobe, $past(busy))
    // an accepted event holds the block busy
    `NRMT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // more words follow a word that is not the last
    `NRMT_ASSERT_NOW(a_more_busy, response_strobe && !response.last, busy)
    // the last word is not followed by another at once
    `NRMT_ASSERT_NEXT(a_last_gap, response_strobe && response.last, !response_strobe)

endmodule

bind node_rank_membership_table nrmt_checker u_nrmt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .response_strobe (response_strobe),
    .response        (response)
);
